// ===== hw/rtl/dpcc_pkg.sv =====
// dpcc_pkg: shared types and constants for the dual-polarization cross-correlator
// no dependencies; imported by every module of the block
package dpcc_pkg;

  localparam int FIELD_BITS = 16;  // width of one sample field on the input bus
  localparam int NUM_FIELDS = 8;   // sample fields per input transfer
  localparam int NUM_POL    = 4;   // polarization products per station pair

  // polarization pair code, also the result order of a dump
  typedef enum logic [1:0] {
    POL_XX = 2'd0,
    POL_XY = 2'd1,
    POL_YX = 2'd2,
    POL_YY = 2'd3
  } pol_t;

  // pipeline control seen by the accumulator stage
  typedef struct packed {
    logic adv;    // pipeline moves this cycle
    logic valid;  // product stage holds an item
    logic last;   // that item closes the integration
  } pipe_ctl_t;

endpackage

// ===== hw/rtl/dual_pol_cross_correlator.sv =====
// dual_pol_cross_correlator: top level, input register, product stage,
// accumulators and dump sequencer; depends on dpcc_pkg and the dpcc_* modules
//
// Takes one time step of two dual-polarization stations per transfer, one
// transfer per cycle while in_tready is high, and accumulates xx, xy, yx and
// yy cross products with saturation to ACC_BITS. The pipeline is input
// register, product register, accumulator. A step marked with in_tlast
// closes the integration: its sums go to a single dump buffer, the
// accumulators clear, and four results leave in the order xx, xy, yx, yy,
// the last with out_tlast. Steps are taken every cycle except while a closing
// step waits at the accumulator for the dump buffer to finish sending the
// previous integration, which holds the whole pipeline; the single dump
// buffer thus bounds how often integrations can close, even when out_tready
// stays high.
module dual_pol_cross_correlator #(
  parameter int SAMPLE_BITS = 16,
  parameter int ACC_BITS    = 48,
  localparam int OUT_BITS   = ((2 * ACC_BITS + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // a_x_re, a_x_im, a_y_re, a_y_im, b_x_re, b_x_im, b_y_re, b_y_im (16 each)
  input  logic [127:0]         in_tdata,
  input  logic                 in_tlast,   // last_time
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // corr_re, corr_im (ACC_BITS each), zero fill to whole bytes
  output logic [OUT_BITS-1:0]  out_tdata,
  output logic [1:0]           out_tuser,  // pol_product
  output logic                 out_tlast   // last_out
);
  import dpcc_pkg::*;

  localparam int PROD_BITS = 2 * SAMPLE_BITS + 1;

  logic                                    adv;
  logic [NUM_FIELDS-1:0][SAMPLE_BITS-1:0]  s1_smp_r;
  logic                                    s1_valid_r, s1_last_r;
  logic                                    s2_valid_r, s2_last_r;
  logic [NUM_POL-1:0][PROD_BITS-1:0]       prod_re, prod_im;
  logic [NUM_POL-1:0][ACC_BITS-1:0]        sum_re, sum_im;
  pipe_ctl_t                               ctl;
  logic                                    dump_busy;
  logic                                    dump_load;
  pol_t                                    res_pol;
  logic [ACC_BITS-1:0]                     res_re, res_im;

  // only a closing step has to wait for the dump buffer
  assign adv       = !(s2_valid_r && s2_last_r && dump_busy);
  assign in_tready = adv;
  assign dump_load = adv && s2_valid_r && s2_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_last_r  <= 1'b0;
      s2_valid_r <= 1'b0;
      s2_last_r  <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_tvalid;
      s1_last_r  <= in_tlast;
      s2_valid_r <= s1_valid_r;
      s2_last_r  <= s1_last_r;
    end
  end

  for (genvar i = 0; i < NUM_FIELDS; i++) begin : g_smp
    always_ff @(posedge clk) begin
      if (adv) begin
        s1_smp_r[i] <= in_tdata[FIELD_BITS*i +: SAMPLE_BITS];
      end
    end
  end

  dpcc_cmul #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .PROD_BITS   (PROD_BITS)
  ) u_cmul (
    .clk     (clk),
    .adv     (adv),
    .smp     (s1_smp_r),
    .prod_re (prod_re),
    .prod_im (prod_im)
  );

  assign ctl.adv   = adv;
  assign ctl.valid = s2_valid_r;
  assign ctl.last  = s2_last_r;

  for (genvar k = 0; k < NUM_POL; k++) begin : g_acc
    dpcc_acc #(
      .ACC_BITS  (ACC_BITS),
      .PROD_BITS (PROD_BITS)
    ) u_acc_re (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .prod    (prod_re[k]),
      .sat_sum (sum_re[k])
    );

    dpcc_acc #(
      .ACC_BITS  (ACC_BITS),
      .PROD_BITS (PROD_BITS)
    ) u_acc_im (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .prod    (prod_im[k]),
      .sat_sum (sum_im[k])
    );
  end

  dpcc_dump #(
    .ACC_BITS (ACC_BITS)
  ) u_dump (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (dump_load),
    .sum_re    (sum_re),
    .sum_im    (sum_im),
    .busy      (dump_busy),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res_pol   (res_pol),
    .res_re    (res_re),
    .res_im    (res_im),
    .res_last  (out_tlast)
  );

  assign out_tdata = OUT_BITS'({res_im, res_re});
  assign out_tuser = res_pol;

endmodule

// ===== hw/rtl/dpcc_cmul.sv =====
// dpcc_cmul: four complex products a_p * conj(b_q), registered
// depends on dpcc_pkg
module dpcc_cmul #(
  parameter int SAMPLE_BITS = 16,
  parameter int PROD_BITS   = 2 * SAMPLE_BITS + 1
) (
  input  logic                                                  clk,
  input  logic                                                  adv,
  input  logic [dpcc_pkg::NUM_FIELDS-1:0][SAMPLE_BITS-1:0]      smp,
  output logic [dpcc_pkg::NUM_POL-1:0][PROD_BITS-1:0]           prod_re,
  output logic [dpcc_pkg::NUM_POL-1:0][PROD_BITS-1:0]           prod_im
);
  import dpcc_pkg::*;

  localparam int MUL_BITS = 2 * SAMPLE_BITS;

  logic [NUM_POL-1:0][PROD_BITS-1:0] prod_re_r;
  logic [NUM_POL-1:0][PROD_BITS-1:0] prod_im_r;

  for (genvar p = 0; p < 2; p++) begin : g_pa
    for (genvar q = 0; q < 2; q++) begin : g_pb
      logic signed [SAMPLE_BITS-1:0] ar, ai, br, bi;
      logic signed [MUL_BITS-1:0]    m_rr, m_ii, m_ir, m_ri;
      logic signed [PROD_BITS-1:0]   re_nxt, im_nxt;

      assign ar = $signed(smp[2*p]);
      assign ai = $signed(smp[2*p+1]);
      assign br = $signed(smp[4+2*q]);
      assign bi = $signed(smp[5+2*q]);

      assign m_rr = ar * br;
      assign m_ii = ai * bi;
      assign m_ir = ai * br;
      assign m_ri = ar * bi;

      // re = ar*br + ai*bi, im = ai*br - ar*bi
      assign re_nxt = PROD_BITS'(m_rr) + PROD_BITS'(m_ii);
      assign im_nxt = PROD_BITS'(m_ir) - PROD_BITS'(m_ri);

      always_ff @(posedge clk) begin
        if (adv) begin
          prod_re_r[2*p+q] <= re_nxt;
          prod_im_r[2*p+q] <= im_nxt;
        end
      end
    end
  end

  assign prod_re = prod_re_r;
  assign prod_im = prod_im_r;

endmodule

// ===== hw/rtl/dpcc_acc.sv =====
// dpcc_acc: one saturating accumulator, cleared after an integration closes
// depends on dpcc_pkg
module dpcc_acc #(
  parameter int ACC_BITS  = 48,
  parameter int PROD_BITS = 33
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dpcc_pkg::pipe_ctl_t        ctl,
  input  logic [PROD_BITS-1:0]       prod,
  output logic [ACC_BITS-1:0]        sat_sum
);
  import dpcc_pkg::*;

  localparam int SUM_BITS = ((ACC_BITS > PROD_BITS) ? ACC_BITS : PROD_BITS) + 1;
  localparam int TOP_BITS = SUM_BITS - ACC_BITS + 1;

  logic signed [ACC_BITS-1:0] acc_r;
  logic signed [ACC_BITS-1:0] acc_nxt;
  logic signed [SUM_BITS-1:0] sum;
  logic                       ovf;
  logic [ACC_BITS-1:0]        sat_val;

  assign sum = SUM_BITS'(acc_r) + SUM_BITS'($signed(prod));

  // out of range when the bits above the acc sign bit disagree with it
  assign ovf = (sum[SUM_BITS-1:ACC_BITS-1] != {TOP_BITS{sum[SUM_BITS-1]}});

  always_comb begin
    if (!ovf) begin
      sat_val = sum[ACC_BITS-1:0];
    end else if (sum[SUM_BITS-1]) begin
      sat_val = {1'b1, {(ACC_BITS-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(ACC_BITS-1){1'b1}}};
    end
  end

  assign sat_sum = sat_val;

  always_comb begin
    acc_nxt = acc_r;
    if (ctl.adv && ctl.valid) begin
      acc_nxt = ctl.last ? '0 : $signed(sat_val);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

endmodule

// ===== hw/rtl/dpcc_dump.sv =====
// dpcc_dump: holds the four closed sums and sends them one transfer at a time
// depends on dpcc_pkg
module dpcc_dump #(
  parameter int ACC_BITS = 48
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        load,
  input  logic [dpcc_pkg::NUM_POL-1:0][ACC_BITS-1:0]  sum_re,
  input  logic [dpcc_pkg::NUM_POL-1:0][ACC_BITS-1:0]  sum_im,
  output logic                                        busy,
  output logic                                        res_valid,
  input  logic                                        res_ready,
  output dpcc_pkg::pol_t                              res_pol,
  output logic [ACC_BITS-1:0]                         res_re,
  output logic [ACC_BITS-1:0]                         res_im,
  output logic                                        res_last
);
  import dpcc_pkg::*;

  logic [NUM_POL-1:0][ACC_BITS-1:0] buf_re_r;
  logic [NUM_POL-1:0][ACC_BITS-1:0] buf_im_r;
  logic [1:0]                       idx_r, idx_nxt;
  logic                             busy_r, busy_nxt;
  logic                             is_last;

  assign is_last = (pol_t'(idx_r) == POL_YY);

  always_comb begin
    idx_nxt  = idx_r;
    busy_nxt = busy_r;
    if (load) begin
      idx_nxt  = 2'(POL_XX);
      busy_nxt = 1'b1;
    end else if (busy_r && res_ready) begin
      idx_nxt = idx_r + 2'd1;
      if (is_last) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= 2'(POL_XX);
      busy_r <= 1'b0;
    end else begin
      idx_r  <= idx_nxt;
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_re_r <= sum_re;
      buf_im_r <= sum_im;
    end
  end

  assign busy      = busy_r;
  assign res_valid = busy_r;
  assign res_pol   = pol_t'(idx_r);
  assign res_re    = buf_re_r[idx_r];
  assign res_im    = buf_im_r[idx_r];
  assign res_last  = busy_r && is_last;

endmodule

// ===== hw/rtl/dpcc_checker.sv =====
// dpcc_checker: port-level assertions on the result stream of the correlator
// depends on dpcc_pkg; bound to dual_pol_cross_correlator below
module dpcc_checker #(
  parameter int OUT_BITS = 96
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_tvalid,
  input logic                 out_tready,
  input logic [OUT_BITS-1:0]  out_tdata,
  input logic [1:0]           out_tuser,
  input logic                 out_tlast
);
  import dpcc_pkg::*;

  // a dump always opens with the xx product
  a_dump_starts_xx : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> (out_tuser == POL_XX))
    else $error("dump does not start with xx");

  // a transfer that is not the last is followed at once by the next pair
  a_dump_in_order : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=>
      (out_tvalid && (out_tuser == $past(out_tuser) + 2'd1)))
    else $error("dump results out of order or broken off");

  // the closing flag sits on the yy product only
  a_last_on_yy : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tuser == POL_YY)))
    else $error("out_tlast does not match yy");

  a_hold_on_stall : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("result changed while stalled");

endmodule

bind dual_pol_cross_correlator dpcc_checker #(
  .OUT_BITS (OUT_BITS)
) u_dpcc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// ===== test/dual_pol_cross_correlator_tb.sv =====
// testbench for dual_pol_cross_correlator: streams dual-pol sample pairs, predicts the
// four saturated cross products per integration and checks every result transfer
// depends on dpcc_pkg and the dual_pol_cross_correlator rtl
`timescale 1ns / 100ps

typedef struct packed {
  logic signed [15:0] b_y_im, b_y_re, b_x_im, b_x_re;
  logic signed [15:0] a_y_im, a_y_re, a_x_im, a_x_re;
} dp_samples_t;  // a_x_re sits in bits 15:0, matching in_tdata

typedef struct {
  dpcc_pkg::pol_t     pol;
  logic signed [47:0] re;
  logic signed [47:0] im;
  logic               last;
} corr_result_t;

class corr_scoreboard;
  localparam longint ACC_HI = (longint'(1) <<< 47) - 1;
  localparam longint ACC_LO = -(longint'(1) <<< 47);

  longint       acc_re[4];
  longint       acc_im[4];
  corr_result_t dump_q[$];
  int           errors;

  function new();
    for (int k = 0; k < 4; k++) begin
      acc_re[k] = 0;
      acc_im[k] = 0;
    end
    errors = 0;
  endfunction

  function longint sat_acc(longint acc, longint t);
    longint sum;
    sum = acc + t;
    if (sum > ACC_HI) return ACC_HI;
    if (sum < ACC_LO) return ACC_LO;
    return sum;
  endfunction

  // one accepted time step: accumulate a_p * conj(b_q), dump on last
  function void note_step(dp_samples_t s, bit last);
    longint ar[2], ai[2], br[2], bi[2];
    longint re, im;
    int idx;
    corr_result_t r;
    ar[0] = $signed(s.a_x_re); ai[0] = $signed(s.a_x_im);
    ar[1] = $signed(s.a_y_re); ai[1] = $signed(s.a_y_im);
    br[0] = $signed(s.b_x_re); bi[0] = $signed(s.b_x_im);
    br[1] = $signed(s.b_y_re); bi[1] = $signed(s.b_y_im);
    for (int p = 0; p < 2; p++) begin
      for (int q = 0; q < 2; q++) begin
        idx = p * 2 + q;
        re = ar[p] * br[q] + ai[p] * bi[q];
        im = ai[p] * br[q] - ar[p] * bi[q];
        acc_re[idx] = sat_acc(acc_re[idx], re);
        acc_im[idx] = sat_acc(acc_im[idx], im);
      end
    end
    if (!last) return;
    for (int k = 0; k < 4; k++) begin
      r.pol  = dpcc_pkg::pol_t'(k);
      r.re   = acc_re[k][47:0];
      r.im   = acc_im[k][47:0];
      r.last = (k == 3);
      dump_q.push_back(r);
      acc_re[k] = 0;
      acc_im[k] = 0;
    end
  endfunction

  function void check_result(logic [1:0] pol, logic [47:0] re, logic [47:0] im, logic last);
    corr_result_t r;
    if (dump_q.size() == 0) begin
      $error("result with nothing expected: pol %0d re %0d im %0d", pol, $signed(re),
             $signed(im));
      errors++;
      return;
    end
    r = dump_q.pop_front();
    if (pol !== r.pol) begin
      $error("pol_product: expected %0d, got %0d", r.pol, pol);
      errors++;
    end
    if (re !== r.re) begin
      $error("corr_re: expected %0d, got %0d", r.re, $signed(re));
      errors++;
    end
    if (im !== r.im) begin
      $error("corr_im: expected %0d, got %0d", r.im, $signed(im));
      errors++;
    end
    if (last !== r.last) begin
      $error("last_out: expected %0d, got %0d", r.last, last);
      errors++;
    end
  endfunction

  function int pending();
    return dump_q.size();
  endfunction
endclass

module dual_pol_cross_correlator_tb;
  import dpcc_pkg::*;

  localparam int OUT_BITS     = 96;
  localparam int RANDOM_STEPS = 100;
  localparam int SAT_STEPS    = 4;      // full-scale steps per long integration
  localparam int HOLD_AT      = 28;     // result count at which the sink holds off
  localparam int HOLD_CYCLES  = 200;
  localparam int STALL_LIMIT  = 1000;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [127:0]        in_tdata   = '0;
  logic                in_tlast   = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_BITS-1:0] out_tdata;
  logic [1:0]          out_tuser;
  logic                out_tlast;

  corr_scoreboard sb = new();
  bit             flat_feed = 1'b0;
  int             tx_calm = 0;
  int             rx_calm = 0;
  int             stall_cycles = 0;

  always #5 clk = ~clk;

  dual_pol_cross_correlator #(
    .SAMPLE_BITS(16),
    .ACC_BITS   (48)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  // mostly random gaps, with occasional runs of back-to-back transfers
  function automatic int draw_gap(ref int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) calm_left = $urandom_range(8, 24);
    return $urandom_range(0, 9);
  endfunction

  function automatic dp_samples_t pack8(int axr, int axi, int ayr, int ayi,
                                        int bxr, int bxi, int byr, int byi);
    dp_samples_t s;
    s.a_x_re = axr[15:0]; s.a_x_im = axi[15:0];
    s.a_y_re = ayr[15:0]; s.a_y_im = ayi[15:0];
    s.b_x_re = bxr[15:0]; s.b_x_im = bxi[15:0];
    s.b_y_re = byr[15:0]; s.b_y_im = byi[15:0];
    return s;
  endfunction

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic dp_samples_t rand_samples();
    return {rand_sample(), rand_sample(), rand_sample(), rand_sample(),
            rand_sample(), rand_sample(), rand_sample(), rand_sample()};
  endfunction

  task automatic send_step(dp_samples_t s, bit last);
    int gap;
    gap = flat_feed ? 0 : draw_gap(tx_calm);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_step(s, last);
  endtask

  // result sink with random stalls and one long hold-off
  initial begin : result_sink
    int gap;
    int got;
    bit held;
    got  = 0;
    held = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (!held && got == HOLD_AT) begin
        gap  = HOLD_CYCLES;
        held = 1'b1;
      end else begin
        gap = draw_gap(rx_calm);
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      sb.check_result(out_tuser, out_tdata[47:0], out_tdata[95:48], out_tlast);
      got++;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int sent;
    int len;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // single-step dumps at the extremes
    send_step(pack8(0, 0, 0, 0, 0, 0, 0, 0), 1'b1);
    send_step(pack8(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768), 1'b1);
    send_step(pack8(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767), 1'b1);
    send_step(pack8(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767), 1'b1);
    // distinct values per pol to pin down result order and conjugate signs
    send_step(pack8(1, 0, 0, 2, 3, 0, 0, 5), 1'b1);
    send_step(pack8(0, 1, 1, 0, 1, 0, 0, -1), 1'b1);
    send_step(pack8(32767, -32768, -32768, 32767, -32768, 32767, 32767, -32768), 1'b1);
    // short integration
    send_step(pack8(-1, -1, -1, -1, -1, -1, -1, -1), 1'b0);
    send_step(pack8(32767, -32768, 1, -1, -32768, 32767, -1, 1), 1'b0);
    send_step(pack8(100, -200, 300, -400, 500, -600, 700, -800), 1'b0);
    send_step(pack8(-32768, 0, 0, 32767, 0, -32768, 32767, 0), 1'b1);
    // closing steps in a row, with random gaps, against the single dump buffer
    repeat (3) send_step(rand_samples(), 1'b1);

    // full-scale integrations fed back to back, large positive and negative sums
    flat_feed = 1'b1;
    for (int i = 0; i < SAT_STEPS; i++)
      send_step(pack8(-32768, -32768, 32767, -32768, -32768, -32768, -32768, 32767), 1'b0);
    send_step(rand_samples(), 1'b0);
    send_step(rand_samples(), 1'b1);
    for (int i = 0; i < SAT_STEPS; i++)
      send_step(pack8(-32768, -32768, -32768, 32767, 32767, 32767, 32767, -32768), 1'b0);
    send_step(rand_samples(), 1'b1);
    flat_feed = 1'b0;

    // random integrations of short length
    sent = 0;
    while (sent < RANDOM_STEPS) begin
      len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        send_step(rand_samples(), i == len - 1);
        sent++;
      end
    end
    in_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
